// ----- src/awld_pkg.sv -----
// Shared types and codes for the word-length deframer.
`default_nettype none
package awld_pkg;

  // Deframer phase codes
  localparam logic [1:0] PH_FIRST = 2'd0;  // expecting first length byte
  localparam logic [1:0] PH_MORE  = 2'd1;  // collecting further length bytes
  localparam logic [1:0] PH_WORD  = 2'd2;  // passing word bytes
  localparam logic [1:0] PH_HALT  = 2'd3;  // stopped after a bad prefix

  // Result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam int unsigned LenW = 32;

  typedef struct packed {
    logic [1:0]      phase;
    logic [2:0]      extra_left;
    logic [LenW-1:0] len_acc;
    logic [LenW-1:0] word_left;
  } awld_state_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       last_of_word;
  } awld_result_t;

endpackage
`default_nettype wire

// ----- src/awld_step.sv -----
// Per-byte next-state and result logic of the deframer.
`default_nettype none
module awld_step (
  input  wire awld_pkg::awld_state_t  state,
  input  wire logic [7:0]             rx_byte,
  output awld_pkg::awld_state_t       state_nxt,
  output awld_pkg::awld_result_t      result
);

  logic [2:0]                extra_dec;
  logic [awld_pkg::LenW-1:0] acc_shift;

  assign extra_dec = state.extra_left - 3'd1;
  assign acc_shift = {state.len_acc[awld_pkg::LenW-9:0], rx_byte};

  always_comb begin
    state_nxt          = state;
    result.valid       = 1'b0;
    result.kind        = awld_pkg::KIND_DATA;
    result.data_byte   = 8'd0;
    result.last_of_word = 1'b0;

    unique case (state.phase)
      awld_pkg::PH_FIRST: begin
        // decode the length prefix of the first byte
        priority if (rx_byte == 8'd0) begin
          result.valid = 1'b1;
          result.kind  = awld_pkg::KIND_END;
        end else if (rx_byte[7] == 1'b0) begin
          state_nxt.word_left = {{(awld_pkg::LenW-8){1'b0}}, rx_byte};
          state_nxt.phase     = awld_pkg::PH_WORD;
        end else if (rx_byte[7:6] == 2'b10) begin
          state_nxt.len_acc    = {{(awld_pkg::LenW-6){1'b0}}, rx_byte[5:0]};
          state_nxt.extra_left = 3'd1;
          state_nxt.phase      = awld_pkg::PH_MORE;
        end else if (rx_byte[7:5] == 3'b110) begin
          state_nxt.len_acc    = {{(awld_pkg::LenW-5){1'b0}}, rx_byte[4:0]};
          state_nxt.extra_left = 3'd2;
          state_nxt.phase      = awld_pkg::PH_MORE;
        end else if (rx_byte[7:4] == 4'b1110) begin
          state_nxt.len_acc    = {{(awld_pkg::LenW-4){1'b0}}, rx_byte[3:0]};
          state_nxt.extra_left = 3'd3;
          state_nxt.phase      = awld_pkg::PH_MORE;
        end else if (rx_byte[7:3] == 5'b11110) begin
          // four full length bytes follow, first byte adds nothing
          state_nxt.len_acc    = '0;
          state_nxt.extra_left = 3'd4;
          state_nxt.phase      = awld_pkg::PH_MORE;
        end else begin
          result.valid    = 1'b1;
          result.kind     = awld_pkg::KIND_ERROR;
          state_nxt.phase = awld_pkg::PH_HALT;
        end
      end

      awld_pkg::PH_MORE: begin
        // append one length byte; an all-zero length means an empty word
        state_nxt.len_acc    = acc_shift;
        state_nxt.extra_left = extra_dec;
        if (extra_dec == 3'd0) begin
          if (acc_shift == '0) begin
            state_nxt.phase = awld_pkg::PH_FIRST;
          end else begin
            state_nxt.word_left = acc_shift;
            state_nxt.phase     = awld_pkg::PH_WORD;
          end
        end
      end

      awld_pkg::PH_WORD: begin
        // pass the data byte; a count of one or zero ends the word
        result.valid     = 1'b1;
        result.data_byte = rx_byte;
        if (state.word_left <= {{(awld_pkg::LenW-1){1'b0}}, 1'b1}) begin
          result.last_of_word = 1'b1;
          state_nxt.word_left = '0;
          state_nxt.phase     = awld_pkg::PH_FIRST;
        end else begin
          state_nxt.word_left = state.word_left - {{(awld_pkg::LenW-1){1'b0}}, 1'b1};
        end
      end

      default: begin
        // halted: drop every byte
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- src/api_word_length_deframer.sv -----
// Top level of the length-prefixed word deframer.
//
// Input channel (in_valid/in_ready/in_rx_byte) takes one received byte per
// word handshake. Each byte updates the deframer state and gives at most one
// result on the output channel (out_valid/out_ready, out_kind,
// out_data_byte, out_last_of_word): a word data byte, an end of sentence
// or a length error. Length bytes give no result.
// A result is registered and appears on the output in the cycle after
// its byte is accepted. Throughput: one byte per cycle while out_ready is
// high, set by the single state update ahead of the output register.
// The output register is freed in the cycle it is taken, so in_ready stays
// high while out_ready is high. When the receiver stalls with a result held,
// in_ready drops until that result is taken; the held result stays stable.
// Reset (rst_n low, synchronous) empties the output register and returns
// the deframer to waiting for a first length byte. After a bad prefix the
// error result is given once and every further byte is accepted and
// dropped until reset.
`default_nettype none
module api_word_length_deframer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_data_byte,
  output logic            out_last_of_word
);

  awld_pkg::awld_state_t  state_r;
  awld_pkg::awld_state_t  state_nxt;
  awld_pkg::awld_result_t result;
  awld_pkg::awld_result_t res_r;
  logic                   in_fire;

  assign in_ready = !res_r.valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  awld_step u_step (
    .state     (state_r),
    .rx_byte   (in_rx_byte),
    .state_nxt (state_nxt),
    .result    (result)
  );

  // deframer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase      <= awld_pkg::PH_FIRST;
      state_r.extra_left <= 3'd0;
      state_r.len_acc    <= '0;
      state_r.word_left  <= '0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // output register: valid clears when taken, payload loads with each result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
    end else begin
      if (in_fire) begin
        res_r.valid <= result.valid;
      end else if (out_ready) begin
        res_r.valid <= 1'b0;
      end
      if (in_fire && result.valid) begin
        res_r.kind         <= result.kind;
        res_r.data_byte    <= result.data_byte;
        res_r.last_of_word <= result.last_of_word;
      end
    end
  end

  assign out_valid        = res_r.valid;
  assign out_kind         = res_r.kind;
  assign out_data_byte    = res_r.data_byte;
  assign out_last_of_word = res_r.last_of_word;

endmodule
`default_nettype wire

// ----- src/awld_checker.sv -----
// Port-level checks for the deframer, bound to the top level.
`default_nettype none
module awld_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [7:0] in_rx_byte,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_kind,
  input wire logic [7:0] out_data_byte,
  input wire logic       out_last_of_word
);

  // a waiting input word holds its byte
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_rx_byte))
    else $error("waiting input changed");

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_data_byte) && $stable(out_last_of_word))
    else $error("stalled result changed");

  // an empty output stage never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // non-data results carry no byte and no last flag
  a_ctrl_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != awld_pkg::KIND_DATA |->
      out_data_byte == 8'd0 && !out_last_of_word)
    else $error("control result carries data");

  // once a length error is taken, no result follows it
  a_error_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_kind == awld_pkg::KIND_ERROR |=> !out_valid)
    else $error("result after length error");

endmodule

bind api_word_length_deframer awld_checker u_awld_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_rx_byte       (in_rx_byte),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_kind         (out_kind),
  .out_data_byte    (out_data_byte),
  .out_last_of_word (out_last_of_word)
);
`default_nettype wire

// ----- tb/sv/api_word_length_deframer_test.sv -----
// Self-checking testbench for the length-prefixed word deframer.
module api_word_length_deframer_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Length prefix encodings on the first length byte
  localparam logic [7:0] END_OF_SENTENCE = 8'h00;
  localparam logic [7:0] LEN_PFX_ONE     = 8'h80;
  localparam logic [7:0] LEN_PFX_TWO     = 8'hC0;
  localparam logic [7:0] LEN_PFX_THREE   = 8'hE0;
  localparam logic [7:0] LEN_PFX_FOUR    = 8'hF0;
  localparam logic [7:0] BAD_PFX_LOW     = 8'hF8;
  localparam logic [7:0] BAD_PFX_HIGH    = 8'hFF;

  localparam int unsigned ItemTarget  = 1200;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned HoldCycles  = 60;
  localparam int unsigned IdlePercent = 38;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       last_of_word;
  } deframe_out_t;

  // Tracks deframer state and the results each accepted byte owes
  class deframe_scoreboard;
    logic [1:0]  phase;
    logic [2:0]  extra_left;
    logic [31:0] len_acc;
    logic [31:0] word_left;
    deframe_out_t pending_outputs[$];
    int unsigned error_count;

    function new();
      phase       = awld_pkg::PH_FIRST;
      extra_left  = '0;
      len_acc     = '0;
      word_left   = '0;
      error_count = 0;
    endfunction

    function void push_out(logic [1:0] kind, logic [7:0] data, logic last);
      deframe_out_t r;
      r.kind         = kind;
      r.data_byte    = data;
      r.last_of_word = last;
      pending_outputs.push_back(r);
    endfunction

    // Advance the predicted deframer by one received byte
    function void note_byte(logic [7:0] b);
      case (phase)
        awld_pkg::PH_FIRST: begin
          if (b == END_OF_SENTENCE) begin
            push_out(awld_pkg::KIND_END, 8'h00, 1'b0);
          end else if (!b[7]) begin
            word_left = {24'h0, b};
            phase     = awld_pkg::PH_WORD;
          end else if (b[7:6] == 2'b10) begin
            len_acc    = {26'h0, b[5:0]};
            extra_left = 3'd1;
            phase      = awld_pkg::PH_MORE;
          end else if (b[7:5] == 3'b110) begin
            len_acc    = {27'h0, b[4:0]};
            extra_left = 3'd2;
            phase      = awld_pkg::PH_MORE;
          end else if (b[7:4] == 4'b1110) begin
            len_acc    = {28'h0, b[3:0]};
            extra_left = 3'd3;
            phase      = awld_pkg::PH_MORE;
          end else if (b[7:3] == 5'b11110) begin
            len_acc    = '0;
            extra_left = 3'd4;
            phase      = awld_pkg::PH_MORE;
          end else begin
            phase = awld_pkg::PH_HALT;
            push_out(awld_pkg::KIND_ERROR, 8'h00, 1'b0);
          end
        end
        awld_pkg::PH_MORE: begin
          len_acc    = {len_acc[23:0], b};
          extra_left = extra_left - 3'd1;
          if (extra_left == 3'd0) begin
            // a length that comes to zero is an empty word
            if (len_acc == 32'h0) begin
              phase = awld_pkg::PH_FIRST;
            end else begin
              word_left = len_acc;
              phase     = awld_pkg::PH_WORD;
            end
          end
        end
        awld_pkg::PH_WORD: begin
          if (word_left == 32'h0) word_left = 32'h1;
          word_left = word_left - 32'h1;
          if (word_left == 32'h0) phase = awld_pkg::PH_FIRST;
          push_out(awld_pkg::KIND_DATA, b, word_left == 32'h0);
        end
        default: ;  // halted: bytes dropped
      endcase
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      error_count++;
    endtask

    task check_result(logic [1:0] kind, logic [7:0] data, logic last);
      deframe_out_t want;
      if (pending_outputs.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind=%0d data=%02h last=%0b",
                                  kind, data, last));
        return;
      end
      want = pending_outputs[0];
      pending_outputs.delete(0);
      if (kind !== want.kind)
        report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
      if (data !== want.data_byte)
        report_mismatch($sformatf("data_byte %02h, want %02h", data, want.data_byte));
      if (last !== want.last_of_word)
        report_mismatch($sformatf("last_of_word %0b, want %0b", last, want.last_of_word));
    endtask

    function int outstanding();
      return pending_outputs.size();
    endfunction
  endclass

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_data_byte;
  logic       out_last_of_word;

  deframe_scoreboard sb = new();
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned bytes_sent = 0;
  int unsigned quiet_cycles = 0;

  api_word_length_deframer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_data_byte    (out_data_byte),
    .out_last_of_word (out_last_of_word)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Receiver: random back-pressure, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (idle_on) begin
      out_ready <= ($urandom_range(99) >= IdlePercent);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result check and stall watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        sb.check_result(out_kind, out_data_byte, out_last_of_word);
      if ((out_valid && out_ready) || (in_valid && in_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= StallLimit) begin
          $display("timeout: no word moved for %0d cycles", StallLimit);
          $display("api_word_length_deframer_test NOT OK");
          $finish;
        end
      end
    end
  end

  // Offer one byte; called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b);
    while (idle_on && $urandom_range(99) < IdlePercent) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Stop offering until every owed result has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  // Length field in the requested number of extra length bytes
  task automatic send_length(input logic [31:0] len, input int unsigned extras);
    case (extras)
      0: send_byte(len[7:0]);
      1: begin
        send_byte(LEN_PFX_ONE | {2'b00, len[13:8]});
        send_byte(len[7:0]);
      end
      2: begin
        send_byte(LEN_PFX_TWO | {3'b000, len[20:16]});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      3: begin
        send_byte(LEN_PFX_THREE | {4'h0, len[27:24]});
        send_byte(len[23:16]);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        // low three prefix bits are ignored by the deframer
        send_byte(LEN_PFX_FOUR | 8'($urandom_range(7)));
        send_byte(len[31:24]);
        send_byte(len[23:16]);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
    endcase
  endtask

  task automatic send_word(input logic [31:0] len, input int unsigned extras);
    send_length(len, extras);
    for (int unsigned i = 0; i < len; i++) send_byte(8'($urandom_range(255)));
  endtask

  initial begin
    int unsigned pick;
    logic [31:0] len;
    bit          hold_done;
    bit          pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: end of sentence, every prefix, empty words, data extremes
    send_byte(END_OF_SENTENCE);
    send_byte(8'h01); send_byte(8'hFF);
    send_byte(8'h02); send_byte(8'h00); send_byte(8'h80);
    send_byte(LEN_PFX_ONE); send_byte(8'h01); send_byte(8'h55);
    send_byte(LEN_PFX_ONE); send_byte(8'h00);
    send_byte(LEN_PFX_TWO); send_byte(8'h00); send_byte(8'h00);
    send_byte(LEN_PFX_THREE); send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);
    send_byte(8'hF7); send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);
    send_byte(8'h01); send_byte(8'hAA);
    send_byte(END_OF_SENTENCE);
    send_word(32'd127, 0);

    // Random well-formed words and sentence ends
    while (bytes_sent < ItemTarget) begin
      idle_on = !(bytes_sent >= 800 && bytes_sent < 1000);
      if (!hold_done && bytes_sent >= 300) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (!pause_done && bytes_sent >= 600) begin
        wait_drained();
        pause_done = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 10) begin
        send_byte(END_OF_SENTENCE);
      end else if (pick < 17) begin
        send_length(32'h0, $urandom_range(1, 4));
      end else begin
        pick = $urandom_range(99);
        if (pick < 70)      len = $urandom_range(1, 8);
        else if (pick < 93) len = $urandom_range(9, 40);
        else if (pick < 99) len = $urandom_range(41, 127);
        else                len = $urandom_range(128, 300);
        send_word(len, (len < 128) ? $urandom_range(0, 4) : $urandom_range(1, 4));
      end
    end
    idle_on = 1'b1;

    // Bad prefix halts the deframer; the trailing words are dropped
    send_byte(8'($urandom_range(BAD_PFX_LOW, BAD_PFX_HIGH)));
    repeat (20) send_byte(8'($urandom_range(255)));

    wait_drained();
    repeat (8) @(negedge clk);
    if (sb.error_count == 0) begin
      $display("api_word_length_deframer_test OK");
    end else begin
      $display("api_word_length_deframer_test NOT OK");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/awld_pkg.sv
src/awld_step.sv
src/api_word_length_deframer.sv
src/awld_checker.sv
tb/sv/api_word_length_deframer_test.sv
